>>> hw/rtl/awna_pkg.sv
// Package for the area-weighted node averaging core: widths, constants, kind codes.
// No dependencies.
`default_nettype none
package awna_pkg;
  localparam int NODE_COUNT_DEF = 4096;
  localparam int IDX_W = 12;
  localparam int DATA_W = 32;
  localparam int ACC_W = 64;
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_ACCUM  = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic [IDX_W-1:0]         node_a;
    logic [IDX_W-1:0]         node_b;
    logic [IDX_W-1:0]         node_c;
    logic signed [DATA_W-1:0] area;
    logic signed [DATA_W-1:0] value;
    logic                     active;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] node_average;
    logic                     no_weight;
    logic                     overflowed;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input word
    logic             mul;       // capture product
    logic             rd;        // issue memory read at addr
    logic             wr;        // write back updated node
    logic             clr;       // write zero at addr
    logic [IDX_W-1:0] addr;
    logic             div_start;
    logic             div_step;
    logic             res_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_zero;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/awna_if.sv
// Valid/ready stream interfaces for input and result words.
// Depends on awna_pkg.
`default_nettype none
interface awna_in_if import awna_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface awna_out_if import awna_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/awna_datapath.sv
// Datapath: node memories, multiplier, saturating adders, restoring divider.
// Depends on awna_pkg.
`default_nettype none
module awna_datapath import awna_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     cfg_abs,
  input  wire in_word_t in_word,
  input  wire cmd_t     cmd,
  output stat_t         stat,
  output out_word_t     res
);
  logic signed [ACC_W-1:0] sum_mem [NODE_COUNT];
  logic signed [ACC_W-1:0] wt_mem  [NODE_COUNT];
  logic                    sat_mem [NODE_COUNT];
  logic [IDX_W-1:0] addr_r;
  logic             oor_r;

  logic signed [DATA_W-1:0] val_r;
  logic signed [ACC_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]  sum_q_r, wt_q_r;
  logic                     sat_q_r;

  logic signed [DATA_W:0] wt_ext;
  always_comb begin
    wt_ext = {in_word.area[DATA_W-1], in_word.area};
    if (cfg_abs && in_word.area[DATA_W-1]) wt_ext = -wt_ext;
  end
  logic signed [DATA_W:0] wt33_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wt33_r <= wt_ext;
      val_r  <= in_word.value;
    end
    if (cmd.mul) prod_r <= ACC_W'(wt33_r * val_r);
  end

  // saturating adds
  logic signed [ACC_W-1:0] s_add, w_add, wt64;
  logic s_ov, w_ov;
  localparam logic signed [ACC_W-1:0] MAXV = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = {1'b1, {(ACC_W-1){1'b0}}};
  always_comb begin
    wt64  = ACC_W'(wt33_r);
    s_add = sum_q_r + prod_r;
    w_add = wt_q_r + wt64;
    s_ov  = (sum_q_r[ACC_W-1] == prod_r[ACC_W-1]) && (s_add[ACC_W-1] != prod_r[ACC_W-1]);
    w_ov  = (wt_q_r[ACC_W-1] == wt64[ACC_W-1]) && (w_add[ACC_W-1] != wt64[ACC_W-1]);
    if (s_ov) s_add = prod_r[ACC_W-1] ? MINV : MAXV;
    if (w_ov) w_add = wt64[ACC_W-1] ? MINV : MAXV;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      sum_q_r <= sum_mem[cmd.addr];
      wt_q_r  <= wt_mem[cmd.addr];
      sat_q_r <= sat_mem[cmd.addr];
      addr_r  <= cmd.addr;
      oor_r   <= (32'(cmd.addr) >= NODE_COUNT);
    end
    if (cmd.clr) begin
      sum_mem[cmd.addr] <= '0;
      wt_mem[cmd.addr]  <= '0;
      sat_mem[cmd.addr] <= 1'b0;
    end else if (cmd.wr) begin
      sum_mem[addr_r] <= s_add;
      wt_mem[addr_r]  <= w_add;
      sat_mem[addr_r] <= sat_q_r | s_ov | w_ov;
    end
  end

  // restoring divider, one quotient bit per step
  logic [ACC_W-1:0] dvd_r, dvs_r, rem_r;
  logic             neg_r;
  logic [ACC_W:0]   trial;
  logic [ACC_W-1:0] rem_sh;
  assign rem_sh = {rem_r[ACC_W-2:0], dvd_r[ACC_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign stat.div_zero = (wt_q_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= sum_q_r[ACC_W-1] ? -sum_q_r : sum_q_r;
      dvs_r <= wt_q_r[ACC_W-1] ? -wt_q_r : wt_q_r;
      rem_r <= '0;
      neg_r <= sum_q_r[ACC_W-1] ^ wt_q_r[ACC_W-1];
    end else if (cmd.div_step) begin
      if (!trial[ACC_W]) rem_r <= trial[ACC_W-1:0];
      else rem_r <= rem_sh;
      dvd_r <= {dvd_r[ACC_W-2:0], ~trial[ACC_W]};
    end
  end

  // dvd_r holds the quotient after ACC_W steps
  logic [DATA_W-1:0] avg;
  always_comb begin
    if (neg_r) begin
      if (dvd_r > ACC_W'(64'h8000_0000)) avg = 32'h8000_0000;
      else avg = DATA_W'(-dvd_r);
    end else begin
      if (dvd_r > ACC_W'(64'h7FFF_FFFF)) avg = 32'h7FFF_FFFF;
      else avg = dvd_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      // a node past the memory reads as empty
      if (oor_r) begin
        res.node_average <= '0;
        res.no_weight    <= 1'b1;
        res.overflowed   <= 1'b0;
      end else begin
        res.node_average <= stat.div_zero ? '0 : avg;
        res.no_weight    <= stat.div_zero;
        res.overflowed   <= sat_q_r;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/awna_ctrl.sv
// Controller: sequences clear sweep, three corner updates, and node reads.
// Depends on awna_pkg.
`default_nettype none
module awna_ctrl import awna_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire stat_t    stat,
  output cmd_t          cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_MUL = 3'd2,
                         S_RD = 3'd3, S_WR = 3'd4, S_DIV = 3'd5, S_RES = 3'd6;
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int DC_W = $clog2(ACC_W + 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] na_r, nb_r, nc_r;
  logic [IDX_W-1:0] cur;
  logic             go;

  // a waiting result sits in the result register; S_RES holds off the next one
  assign in_ready = (state_r == S_IDLE);
  assign go = in_valid && in_ready;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (go) begin
      na_r <= in_word.node_a;
      nb_r <= in_word.node_b;
      nc_r <= in_word.node_c;
    end
  end

  always_comb begin
    unique case (k_r)
      2'd0: cur = na_r;
      2'd1: cur = nb_r;
      default: cur = nc_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    dc_nxt = dc_r;
    ov_nxt = ov_r && !out_ready;
    cmd = '0;
    cmd.addr = cur;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = go;
        if (go) begin
          priority case (in_word.kind)
            KIND_CLEAR: begin
              state_nxt = S_CLR;
              cnt_nxt = '0;
            end
            KIND_ACCUM: if (in_word.active) begin
              state_nxt = S_MUL;
              k_nxt = '0;
            end
            KIND_READ: begin
              cmd.rd = 1'b1;
              cmd.addr = in_word.node_a;
              if (32'(in_word.node_a) >= NODE_COUNT) begin
                // out of range reads as empty node
                state_nxt = S_RES;
              end else state_nxt = S_DIV;
              dc_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        cmd.addr = cnt_r[IDX_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == NODE_COUNT - 1) state_nxt = S_IDLE;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (32'(cur) < NODE_COUNT) begin
          cmd.rd = 1'b1;
          state_nxt = S_WR;
        end else if (k_r == 2'd2) state_nxt = S_IDLE;
        else k_nxt = k_r + 1'b1;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (k_r == 2'd2) state_nxt = S_IDLE;
        else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        if (dc_r == '0) cmd.div_start = 1'b1;
        else cmd.div_step = 1'b1;
        dc_nxt = dc_r + 1'b1;
        if (stat.div_zero || 32'(dc_r) == ACC_W) state_nxt = S_RES;
      end
      S_RES: begin
        if (!ov_nxt) begin
          cmd.res_load = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // reset starts a clear sweep so every node reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      k_r <= '0;
      dc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      k_r <= k_nxt;
      dc_r <= dc_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/area_weighted_node_average_core.sv
// Top level of the area-weighted node averaging core.
// Depends on awna_pkg, awna_if, awna_ctrl, awna_datapath.
//
//  channel | dir | handshake      | word
//  in      | in  | in_valid/ready | kind, node_a..c, area, value, active
//  out     | out | out_valid/ready| node_average, no_weight, overflowed
//  cfg     | in  | cfg_we         | absolute_area
//
// Accumulate: accept, multiply, then read and write back per corner on the
// single-port node memories; an inactive word goes straight back to accept.
// Read: runs the one-bit-per-cycle divider, cut short on zero weight.
// Clear: one node per cycle. After reset the same sweep runs with in_ready low.
// The result register lets the next word in while a result waits; a read then
// holds in S_RES until it drains.
`default_nettype none
module area_weighted_node_average_core import awna_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  awna_in_if.sink   in_ch,
  awna_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata
);
  logic  cfg_abs_r;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_abs_r <= 1'b0;
    else if (cfg_we) cfg_abs_r <= cfg_wdata;
  end

  awna_ctrl #(.NODE_COUNT(NODE_COUNT)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  awna_datapath #(.NODE_COUNT(NODE_COUNT)) u_dp (
    .clk, .cfg_abs(cfg_abs_r), .in_word(in_ch.data),
    .cmd, .stat, .res(out_ch.data)
  );
endmodule
`default_nettype wire
